[design/fhc_pkg.sv]
package fhc_pkg;

  // header_status codes
  localparam logic [1:0] HDR_PARSED  = 2'd0;
  localparam logic [1:0] HDR_SKIPPED = 2'd1;
  localparam logic [1:0] HDR_SHORT   = 2'd2;

  // udp_check_status codes
  localparam logic [2:0] UDP_NONE    = 3'd0;
  localparam logic [2:0] UDP_OMITTED = 3'd1;
  localparam logic [2:0] UDP_GOOD    = 3'd2;
  localparam logic [2:0] UDP_BAD     = 3'd3;
  localparam logic [2:0] UDP_TRUNC   = 3'd4;

  // ip protocol numbers
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // frame layout, byte offsets from the destination mac
  localparam logic [15:0] OFS_TYPE_HI  = 16'd12;
  localparam logic [15:0] OFS_TYPE_LO  = 16'd13;
  localparam logic [15:0] OFS_IP       = 16'd14;
  localparam logic [15:0] OFS_PROTO    = 16'd23;
  localparam logic [15:0] OFS_SRC_LO   = 16'd26;
  localparam logic [15:0] OFS_SRC_HI   = 16'd29;
  localparam logic [15:0] OFS_DST_LO   = 16'd30;
  localparam logic [15:0] OFS_DST_HI   = 16'd33;
  localparam logic [15:0] MIN_PARSE    = 16'd34;
  localparam logic [15:0] MIN_FRAME    = 16'd15;
  localparam logic [7:0]  TCP_HDR_NEED = 8'd14;
  localparam logic [7:0]  UDP_HDR_NEED = 8'd8;

  localparam int unsigned OUT_DATA_W = 152;

  // everything known about a frame once its last byte is in
  typedef struct packed {
    logic [15:0] count;
    logic [3:0]  ihl;
    logic [15:0] ether_type;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [7:0]  flags;
    logic [15:0] udp_len;
    logic [15:0] rx_check;
    logic [15:0] sum;
    logic [7:0]  hold;
  } frame_t;

  // classified frame with the checksum split into two partial sums
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ether_type;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  flags;
    logic [2:0]  udp_code;
    logic        sum_check;
    logic [18:0] sum_a;
    logic [18:0] sum_b;
    logic [15:0] length;
  } class_t;

endpackage

[design/frame_header_classifier_udp_check.sv]
// channel  | dir | tdata                                  | tuser          | tlast
// ---------+-----+----------------------------------------+----------------+----------
// s_axis   | in  | [7:0] data_byte                        | -              | last_byte
// m_axis   | out | ether_type .. frame_length, 147 bits   | header_status  | -
//
// one frame byte is taken every cycle while s_axis_tready is high; a result passes
// three registered stages after the last byte of its frame (capture, classify, checksum verdict)
// the three result stages flow as a pipeline, so one-byte frames still run at
// one transfer per cycle; ready falls only when all three stages hold results
// rst_ni clears the byte counter, the header capture and all stage valids
module frame_header_classifier_udp_check #(
  parameter int unsigned MAX_FRAME_LEN = 65535
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] ether_type, [23:16] ip_protocol, [55:24] source_address,
  // [87:56] dest_address, [103:88] source_port, [119:104] dest_port,
  // [127:120] tcp_flag_bits, [130:128] udp_check_status,
  // [146:131] frame_length, [151:147] zero
  output logic [fhc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // [1:0] header_status
);

  localparam logic [15:0] MaxLen = 16'(MAX_FRAME_LEN);

  // ---------------------------------------------------------------------------
  // pipeline flow control
  // ---------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, out_vld_q;
  logic out_en, s2_en, s1_en, in_xfer;

  assign out_en        = !out_vld_q || m_axis_tready;
  assign s2_en         = !s2_vld_q || out_en;
  assign s1_en         = !s1_vld_q || s2_en;
  assign s_axis_tready = s1_en;
  assign in_xfer       = s_axis_tvalid && s1_en;

  // ---------------------------------------------------------------------------
  // byte capture: running header state for the frame in flight
  // ---------------------------------------------------------------------------
  fhc_pkg::frame_t cur_q, cur_d, upd;

  logic        take;
  logic [3:0]  ihl_eff;
  logic [6:0]  l4_ofs;
  logic        in_l4;
  logic [15:0] rel;
  logic [7:0]  b;
  logic [16:0] pay_sum;

  always_comb begin
    b       = s_axis_tdata;
    take    = cur_q.count < MaxLen;
    upd     = cur_q;
    ihl_eff = (cur_q.count == fhc_pkg::OFS_IP) ? b[3:0] : cur_q.ihl;
    // transport header start, the ihl byte itself counts
    l4_ofs  = 7'd14 + {1'b0, ihl_eff, 2'b00};
    in_l4   = cur_q.count >= {9'd0, l4_ofs};
    rel     = cur_q.count - {9'd0, l4_ofs};
    // one's complement add of the assembled payload word
    pay_sum = {1'b0, cur_q.sum} + {1'b0, cur_q.hold, b};

    if (take) begin
      upd.count = cur_q.count + 16'd1;
      upd.ihl   = ihl_eff;
      if (cur_q.count == fhc_pkg::OFS_TYPE_HI) upd.ether_type = {b, 8'h00};
      if (cur_q.count == fhc_pkg::OFS_TYPE_LO) begin
        upd.ether_type = {cur_q.ether_type[15:8], cur_q.ether_type[7:0] | b};
      end
      if (cur_q.count == fhc_pkg::OFS_PROTO) upd.proto = b;
      if (cur_q.count >= fhc_pkg::OFS_SRC_LO && cur_q.count <= fhc_pkg::OFS_SRC_HI) begin
        upd.src_addr = {cur_q.src_addr[23:0], b};
      end
      if (cur_q.count >= fhc_pkg::OFS_DST_LO && cur_q.count <= fhc_pkg::OFS_DST_HI) begin
        upd.dst_addr = {cur_q.dst_addr[23:0], b};
      end
      // transport fields go by offset, even where they overlap ip header bytes
      if (in_l4) begin
        if (rel <= 16'd3) begin
          upd.ports = {cur_q.ports[23:0], b};
        end else if (rel <= 16'd5) begin
          upd.udp_len = {cur_q.udp_len[7:0], b};
        end else if (rel <= 16'd7) begin
          upd.rx_check = {cur_q.rx_check[7:0], b};
        end
        if (rel == 16'd13) upd.flags = b;
        if (rel >= 16'd8 && rel < cur_q.udp_len) begin
          if (!rel[0]) begin
            upd.hold = b;
          end else begin
            upd.sum = pay_sum[15:0] + {15'd0, pay_sum[16]};
          end
        end
      end
    end

    cur_d = cur_q;
    if (in_xfer) begin
      // a finished frame leaves the capture clean for the next one
      cur_d = s_axis_tlast ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: snapshot of the finished frame
  // ---------------------------------------------------------------------------
  fhc_pkg::frame_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_en) begin
      s1_vld_q <= in_xfer && s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_xfer && s_axis_tlast) begin
      s1_q <= upd;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: classification and partial checksum sums
  // ---------------------------------------------------------------------------
  fhc_pkg::class_t s2_d, s2_q;

  logic [6:0]  f_l4;
  logic [7:0]  f_need8;
  logic [15:0] f_need;
  logic [16:0] f_udp_end;
  logic        f_tcp, f_udp, f_skip;
  logic [15:0] w0, w1, w2, w3, w_hold;
  logic [15:0] ul;

  always_comb begin
    ul      = s1_q.udp_len;
    f_tcp   = s1_q.proto == fhc_pkg::PROTO_TCP;
    f_udp   = s1_q.proto == fhc_pkg::PROTO_UDP;
    f_l4    = 7'd14 + {1'b0, s1_q.ihl, 2'b00};
    f_skip  = s1_q.ihl == 4'd0 || s1_q.ihl == 4'd2 || s1_q.ihl == 4'd8;
    f_need8 = {1'b0, f_l4};
    if (f_tcp) begin
      f_need8 = {1'b0, f_l4} + fhc_pkg::TCP_HDR_NEED;
    end else if (f_udp) begin
      f_need8 = {1'b0, f_l4} + fhc_pkg::UDP_HDR_NEED;
    end
    f_need    = ({8'd0, f_need8} < fhc_pkg::MIN_PARSE) ? fhc_pkg::MIN_PARSE
                                                       : {8'd0, f_need8};
    f_udp_end = {10'd0, f_l4} + {1'b0, ul};

    // udp header words count only below the udp length
    w0 = {(ul > 16'd0) ? s1_q.ports[31:24] : 8'h00,
          (ul > 16'd1) ? s1_q.ports[23:16] : 8'h00};
    w1 = {(ul > 16'd2) ? s1_q.ports[15:8]  : 8'h00,
          (ul > 16'd3) ? s1_q.ports[7:0]   : 8'h00};
    w2 = {(ul > 16'd4) ? ul[15:8] : 8'h00,
          (ul > 16'd5) ? ul[7:0]  : 8'h00};
    w3 = {(ul > 16'd6) ? s1_q.rx_check[15:8] : 8'h00,
          (ul > 16'd7) ? s1_q.rx_check[7:0]  : 8'h00};
    // odd payload leaves a pending high byte padded with zero
    w_hold = (ul > 16'd8 && ul[0]) ? {s1_q.hold, 8'h00} : 16'h0000;

    s2_d = '0;
    s2_d.length = s1_q.count;
    if (s1_q.count < fhc_pkg::MIN_FRAME) begin
      s2_d.status = fhc_pkg::HDR_SHORT;
    end else if (f_skip) begin
      s2_d.status = fhc_pkg::HDR_SKIPPED;
    end else if (s1_q.count < f_need) begin
      s2_d.status = fhc_pkg::HDR_SHORT;
    end else begin
      s2_d.status = fhc_pkg::HDR_PARSED;
    end

    if (s2_d.status == fhc_pkg::HDR_PARSED) begin
      s2_d.ether_type = s1_q.ether_type;
      s2_d.proto      = s1_q.proto;
      s2_d.src_addr   = s1_q.src_addr;
      s2_d.dst_addr   = s1_q.dst_addr;
      if (f_tcp || f_udp) begin
        s2_d.src_port = s1_q.ports[31:16];
        s2_d.dst_port = s1_q.ports[15:0];
      end
      if (f_tcp) s2_d.flags = s1_q.flags;
      if (f_udp) begin
        if (s1_q.rx_check == 16'h0000) begin
          s2_d.udp_code = fhc_pkg::UDP_OMITTED;
        end else if ({1'b0, s1_q.count} < f_udp_end) begin
          s2_d.udp_code = fhc_pkg::UDP_TRUNC;
        end else begin
          s2_d.sum_check = 1'b1;
        end
      end
    end

    s2_d.sum_a = {3'd0, s1_q.sum} + {3'd0, w_hold} + {3'd0, w0} + {3'd0, w1}
               + {3'd0, w2} + {3'd0, w3};
    // pseudo header: addresses, protocol and udp length
    s2_d.sum_b = {3'd0, s1_q.src_addr[31:16]} + {3'd0, s1_q.src_addr[15:0]}
               + {3'd0, s1_q.dst_addr[31:16]} + {3'd0, s1_q.dst_addr[15:0]}
               + {11'd0, fhc_pkg::PROTO_UDP} + {3'd0, ul};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_vld_q) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: checksum verdict and output register
  // ---------------------------------------------------------------------------
  // after one fold the sum is at most 0x1000e, and it folds to 0xffff only
  // when it already is 0xffff
  logic [19:0] tot;
  logic [16:0] fold1;
  logic [2:0]  udp_fin;
  logic [fhc_pkg::OUT_DATA_W-1:0] tdata_d, tdata_q;
  logic [1:0]  tuser_q;

  always_comb begin
    tot     = {1'b0, s2_q.sum_a} + {1'b0, s2_q.sum_b};
    fold1   = {1'b0, tot[15:0]} + {13'd0, tot[19:16]};
    udp_fin = s2_q.udp_code;
    if (s2_q.sum_check) begin
      udp_fin = (fold1 == 17'h0ffff) ? fhc_pkg::UDP_GOOD : fhc_pkg::UDP_BAD;
    end
    tdata_d = {5'd0, s2_q.length, udp_fin, s2_q.flags, s2_q.dst_port, s2_q.src_port,
               s2_q.dst_addr, s2_q.src_addr, s2_q.proto, s2_q.ether_type};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_vld_q) begin
      tdata_q <= tdata_d;
      tuser_q <= s2_q.status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

endmodule
